// ===== rtl/dct8_pkg.sv =====
package dct8_pkg;

    // default sample width and fixed result width
    localparam int DCT8_SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH        = 20;

    // guard bits over the sample width for sums and rotations
    localparam int GROWTH_BITS = 4;

    // q1.15 constants
    localparam int K_WIDTH   = 16;
    localparam int FRAC_BITS = 15;

    localparam logic signed [K_WIDTH-1:0] K_SQRT_HALF = 16'sd23170;
    localparam logic signed [K_WIDTH-1:0] K_COS_1     = 16'sd32138;
    localparam logic signed [K_WIDTH-1:0] K_SIN_1     = 16'sd6393;
    localparam logic signed [K_WIDTH-1:0] K_COS_3     = 16'sd27246;
    localparam logic signed [K_WIDTH-1:0] K_SIN_3     = 16'sd18205;
    localparam logic signed [K_WIDTH-1:0] K_COS_6     = 16'sd12540;
    localparam logic signed [K_WIDTH-1:0] K_SIN_6     = 16'sd30274;

    // pipeline depth, output register included
    localparam int NUM_STAGES = 6;

    // multiplier slots: odd rotations, even rotation, scaling
    localparam int NUM_MULS = 15;

    localparam logic signed [K_WIDTH-1:0] MUL_COEF [NUM_MULS] = '{
        K_COS_3, K_SIN_3, K_COS_3, K_SIN_3,
        K_COS_1, K_SIN_1, K_COS_1, K_SIN_1,
        K_COS_6, K_SIN_6, K_COS_6, K_SIN_6,
        K_SQRT_HALF, K_SQRT_HALF, K_SQRT_HALF
    };

endpackage

// ===== rtl/dct8_sample_if.sv =====
interface dct8_sample_if
    import dct8_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DCT8_SAMPLE_WIDTH
)
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_0;
    logic signed [SAMPLE_WIDTH-1:0] sample_1;
    logic signed [SAMPLE_WIDTH-1:0] sample_2;
    logic signed [SAMPLE_WIDTH-1:0] sample_3;
    logic signed [SAMPLE_WIDTH-1:0] sample_4;
    logic signed [SAMPLE_WIDTH-1:0] sample_5;
    logic signed [SAMPLE_WIDTH-1:0] sample_6;
    logic signed [SAMPLE_WIDTH-1:0] sample_7;

    modport source
    (
        output valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        input  ready
    );

    modport sink
    (
        input  valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        output ready
    );
endinterface

// ===== rtl/dct8_coef_if.sv =====
interface dct8_coef_if
    import dct8_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_0;
    logic signed [COEF_WIDTH-1:0] coef_1;
    logic signed [COEF_WIDTH-1:0] coef_2;
    logic signed [COEF_WIDTH-1:0] coef_3;
    logic signed [COEF_WIDTH-1:0] coef_4;
    logic signed [COEF_WIDTH-1:0] coef_5;
    logic signed [COEF_WIDTH-1:0] coef_6;
    logic signed [COEF_WIDTH-1:0] coef_7;

    modport source
    (
        output valid, coef_0, coef_1, coef_2, coef_3,
               coef_4, coef_5, coef_6, coef_7,
        input  ready
    );

    modport sink
    (
        input  valid, coef_0, coef_1, coef_2, coef_3,
               coef_4, coef_5, coef_6, coef_7,
        output ready
    );
endinterface

// ===== rtl/dct8_qmul.sv =====
// constant multiply in q1.15, rounded to nearest with halves toward +inf
module dct8_qmul
    import dct8_pkg::*;
#(
    parameter int                         WIDTH = DCT8_SAMPLE_WIDTH + GROWTH_BITS,
    parameter logic signed [K_WIDTH-1:0]  COEF  = K_SQRT_HALF
)
(
    input  logic signed [WIDTH-1:0] a,
    output logic signed [WIDTH-1:0] p
);
    localparam int PW = WIDTH + K_WIDTH;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;

    // full product, add half, floor by dropping the fraction
    assign prod = PW'(a) * PW'(COEF);
    assign rnd  = prod + HALF;
    assign p    = rnd[WIDTH+FRAC_BITS-1:FRAC_BITS];
endmodule

// ===== rtl/dct_ii_8_point.sv =====
// channel   dir  modport            beat
// samples   in   dct8_sample_if     eight signed samples, one block
// coefs     out  dct8_coef_if       eight 20-bit dct-ii coefficients
//
// one block enters per cycle while coefs is not stalling the pipe; six register stages
// (butterfly, odd rotations, even rotation, odd sums, last butterfly, scaling)
// each stage holds a valid bit and advances when the stage after it is empty or moving
// a stall on coefs backs up stage by stage; ready drops only when all six stages are full
// rst_n clears the valid bits asynchronously; data registers are not reset
module dct_ii_8_point
    import dct8_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DCT8_SAMPLE_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    dct8_sample_if.sink   samples,
    dct8_coef_if.source   coefs
);
    localparam int IW = SAMPLE_WIDTH + GROWTH_BITS;

    typedef logic signed [IW-1:0] word_t;

    // pipeline control
    logic [NUM_STAGES-1:0] stage_valid_reg;
    logic [NUM_STAGES-1:0] stage_valid_next;
    logic [NUM_STAGES-1:0] stage_ld;

    always_comb
    begin
        stage_ld[NUM_STAGES-1] = !stage_valid_reg[NUM_STAGES-1] || coefs.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_ld[k] = !stage_valid_reg[k] || stage_ld[k+1];
        end
        stage_valid_next[0] = stage_ld[0] ? samples.valid : stage_valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            stage_valid_next[k] = stage_ld[k] ? stage_valid_reg[k-1] : stage_valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign samples.ready = stage_ld[0];
    assign coefs.valid   = stage_valid_reg[NUM_STAGES-1];

    // constant multipliers, one per slot, each fed by a single stage
    word_t mul_a [NUM_MULS];
    word_t mul_p [NUM_MULS];

    for (genvar g = 0; g < NUM_MULS; g++)
    begin : g_mul
        dct8_qmul #(
            .WIDTH (IW),
            .COEF  (MUL_COEF[g])
        ) u_qmul (
            .a (mul_a[g]),
            .p (mul_p[g])
        );
    end

    // stage 1: mirrored sums and differences
    word_t x [8];
    word_t s1_sum_reg [4];
    word_t s1_dif_reg [4];

    always_comb
    begin
        x[0] = IW'(samples.sample_0);
        x[1] = IW'(samples.sample_1);
        x[2] = IW'(samples.sample_2);
        x[3] = IW'(samples.sample_3);
        x[4] = IW'(samples.sample_4);
        x[5] = IW'(samples.sample_5);
        x[6] = IW'(samples.sample_6);
        x[7] = IW'(samples.sample_7);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_sum_reg[i] <= x[i] + x[7-i];
                s1_dif_reg[i] <= x[i] - x[7-i];
            end
        end
    end

    // stage 2: even butterflies, odd rotation products
    word_t s2_es0_reg, s2_ed0_reg, s2_es1_reg, s2_ed1_reg;
    word_t s2_prod_reg [8];

    always_comb
    begin
        mul_a[0] = s1_dif_reg[3];
        mul_a[1] = s1_dif_reg[0];
        mul_a[2] = s1_dif_reg[0];
        mul_a[3] = s1_dif_reg[3];
        mul_a[4] = s1_dif_reg[2];
        mul_a[5] = s1_dif_reg[1];
        mul_a[6] = s1_dif_reg[1];
        mul_a[7] = s1_dif_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[1])
        begin
            s2_es0_reg <= s1_sum_reg[0] + s1_sum_reg[3];
            s2_ed0_reg <= s1_sum_reg[0] - s1_sum_reg[3];
            s2_es1_reg <= s1_sum_reg[1] + s1_sum_reg[2];
            s2_ed1_reg <= s1_sum_reg[1] - s1_sum_reg[2];
            for (int i = 0; i < 8; i++)
            begin
                s2_prod_reg[i] <= mul_p[i];
            end
        end
    end

    // stage 3: odd rotation sums, dc and even difference, even rotation products
    word_t s3_r3x_reg, s3_r3y_reg, s3_r1x_reg, s3_r1y_reg;
    word_t s3_y0_reg, s3_yb_reg;
    word_t s3_prod_reg [4];

    always_comb
    begin
        mul_a[8]  = s2_ed1_reg;
        mul_a[9]  = s2_ed0_reg;
        mul_a[10] = s2_ed0_reg;
        mul_a[11] = s2_ed1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[2])
        begin
            s3_r3x_reg <= s2_prod_reg[0] + s2_prod_reg[1];
            s3_r3y_reg <= s2_prod_reg[2] - s2_prod_reg[3];
            s3_r1x_reg <= s2_prod_reg[4] + s2_prod_reg[5];
            s3_r1y_reg <= s2_prod_reg[6] - s2_prod_reg[7];
            s3_y0_reg  <= s2_es0_reg + s2_es1_reg;
            s3_yb_reg  <= s2_es0_reg - s2_es1_reg;
            for (int i = 0; i < 4; i++)
            begin
                s3_prod_reg[i] <= mul_p[8+i];
            end
        end
    end

    // stage 4: odd butterflies, even rotation sums, coef 4 scaling
    word_t s4_oa_reg, s4_od_reg;
    word_t s4_y0_reg, s4_y2_reg, s4_y3_reg, s4_y4_reg, s4_y5_reg, s4_y6_reg;

    assign mul_a[12] = s3_yb_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ld[3])
        begin
            s4_oa_reg <= s3_r3y_reg + s3_r1x_reg;
            s4_y3_reg <= s3_r3y_reg - s3_r1x_reg;
            s4_od_reg <= s3_r3x_reg + s3_r1y_reg;
            s4_y5_reg <= s3_r3x_reg - s3_r1y_reg;
            s4_y2_reg <= s3_prod_reg[0] + s3_prod_reg[1];
            s4_y6_reg <= s3_prod_reg[2] - s3_prod_reg[3];
            s4_y4_reg <= mul_p[12];
            s4_y0_reg <= s3_y0_reg;
        end
    end

    // stage 5: last odd butterfly
    word_t s5_sum_reg, s5_dif_reg;
    word_t s5_y0_reg, s5_y2_reg, s5_y3_reg, s5_y4_reg, s5_y5_reg, s5_y6_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ld[4])
        begin
            s5_sum_reg <= s4_oa_reg + s4_od_reg;
            s5_dif_reg <= s4_oa_reg - s4_od_reg;
            s5_y0_reg  <= s4_y0_reg;
            s5_y2_reg  <= s4_y2_reg;
            s5_y3_reg  <= s4_y3_reg;
            s5_y4_reg  <= s4_y4_reg;
            s5_y5_reg  <= s4_y5_reg;
            s5_y6_reg  <= s4_y6_reg;
        end
    end

    // stage 6: sqrt one half on coef 1 and 7, output register wrapped to coef width
    logic signed [COEF_WIDTH-1:0] coef_reg [8];

    assign mul_a[13] = s5_sum_reg;
    assign mul_a[14] = s5_dif_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ld[5])
        begin
            coef_reg[0] <= COEF_WIDTH'(s5_y0_reg);
            coef_reg[1] <= COEF_WIDTH'(mul_p[13]);
            coef_reg[2] <= COEF_WIDTH'(s5_y2_reg);
            coef_reg[3] <= COEF_WIDTH'(s5_y3_reg);
            coef_reg[4] <= COEF_WIDTH'(s5_y4_reg);
            coef_reg[5] <= COEF_WIDTH'(s5_y5_reg);
            coef_reg[6] <= COEF_WIDTH'(s5_y6_reg);
            coef_reg[7] <= COEF_WIDTH'(mul_p[14]);
        end
    end

    assign coefs.coef_0 = coef_reg[0];
    assign coefs.coef_1 = coef_reg[1];
    assign coefs.coef_2 = coef_reg[2];
    assign coefs.coef_3 = coef_reg[3];
    assign coefs.coef_4 = coef_reg[4];
    assign coefs.coef_5 = coef_reg[5];
    assign coefs.coef_6 = coef_reg[6];
    assign coefs.coef_7 = coef_reg[7];

`ifndef SYNTHESIS
    // an accepted beat lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> stage_valid_reg[0])
        else $error("accepted beat did not enter stage 1");

    // a full pipe under output stall takes nothing new
    assert property (@(posedge clk) disable iff (!rst_n)
        (&stage_valid_reg) && !coefs.ready |-> !samples.ready)
        else $error("input accepted while pipe full and stalled");

    // a blocked first stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[0] && !stage_ld[1] |=> stage_valid_reg[0])
        else $error("stage 1 beat dropped under stall");

    // output register not overwritten while waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        coefs.valid && !coefs.ready |=> coefs.valid && $stable(coef_reg[0]))
        else $error("stalled result lost");
`endif
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dct8_pkg::*;

    typedef logic [7:0][DCT8_SAMPLE_WIDTH-1:0] block_t;
    typedef logic [7:0][COEF_WIDTH-1:0]        coefs_t;

    localparam logic [DCT8_SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [DCT8_SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [DCT8_SAMPLE_WIDTH-1:0] SAMPLE_ONE = 16'h0001;
    localparam logic [DCT8_SAMPLE_WIDTH-1:0] SAMPLE_NEG = 16'hFFFF;

    localparam int CYCLE_LIMIT = 100000;
    localparam int MAX_REPORTS = 10;

    // q1.15 rotation and scaling factors of the flow graph
    localparam longint Q_ROOT_HALF = 23170;
    localparam longint Q_C1        = 32138;
    localparam longint Q_S1        = 6393;
    localparam longint Q_C3        = 27246;
    localparam longint Q_S3        = 18205;
    localparam longint Q_C6        = 12540;
    localparam longint Q_S6        = 30274;

    // expected coefficient blocks and their comparison
    class dct_scoreboard;
        coefs_t expected_coefs[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // product rounded to nearest, halves toward +inf
        function longint qround(longint v, longint k);
            longint p;
            p = v * k + 64'sd16384;
            return p >>> 15;
        endfunction

        function coefs_t dct8_of(block_t b);
            longint x [8];
            longint s07, s16, s25, s34, d07, d16, d25, d34;
            longint es0, ed0, es1, ed1, r3x, r3y, r1x, r1y, oa, od;
            coefs_t y;
            int     i;
            for (i = 0; i < 8; i++)
                x[i] = longint'($signed(b[i]));
            // mirrored sums and differences
            s07 = x[0] + x[7];
            d07 = x[0] - x[7];
            s16 = x[1] + x[6];
            d16 = x[1] - x[6];
            s25 = x[2] + x[5];
            d25 = x[2] - x[5];
            s34 = x[3] + x[4];
            d34 = x[3] - x[4];
            // even butterflies, odd rotations
            es0 = s07 + s34;
            ed0 = s07 - s34;
            es1 = s16 + s25;
            ed1 = s16 - s25;
            r3x = qround(d34, Q_C3) + qround(d07, Q_S3);
            r3y = qround(d07, Q_C3) - qround(d34, Q_S3);
            r1x = qround(d25, Q_C1) + qround(d16, Q_S1);
            r1y = qround(d16, Q_C1) - qround(d25, Q_S1);
            oa  = r3y + r1x;
            od  = r3x + r1y;
            // last stage, wrapped to coefficient width
            y[0] = COEF_WIDTH'(es0 + es1);
            y[1] = COEF_WIDTH'(qround(oa + od, Q_ROOT_HALF));
            y[2] = COEF_WIDTH'(qround(ed1, Q_C6) + qround(ed0, Q_S6));
            y[3] = COEF_WIDTH'(r3y - r1x);
            y[4] = COEF_WIDTH'(qround(es0 - es1, Q_ROOT_HALF));
            y[5] = COEF_WIDTH'(r3x - r1y);
            y[6] = COEF_WIDTH'(qround(ed0, Q_C6) - qround(ed1, Q_S6));
            y[7] = COEF_WIDTH'(qround(oa - od, Q_ROOT_HALF));
            return y;
        endfunction

        function void note_block(block_t b);
            expected_coefs.push_back(dct8_of(b));
        endfunction

        function int pending();
            return expected_coefs.size();
        endfunction

        function void check_coefs(coefs_t got);
            coefs_t want;
            bit     bad;
            int     i;
            if (expected_coefs.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("coefficient beat with no block pending");
                mismatches++;
                return;
            end
            want = expected_coefs.pop_front();
            bad  = 1'b0;
            for (i = 0; i < 8; i++)
            begin
                if (got[i] !== want[i])
                begin
                    bad = 1'b1;
                    if (mismatches < MAX_REPORTS)
                        $display("coef_%0d mismatch: expected %0d, got %0d",
                                 i, $signed(want[i]), $signed(got[i]));
                end
            end
            if (bad)
                mismatches++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_req;
    int   hold_left;
    int   cycle_count;

    dct_scoreboard sb = new();

    dct8_sample_if samples_if ();
    dct8_coef_if   coefs_if ();

    dct_ii_8_point #(
        .SAMPLE_WIDTH (DCT8_SAMPLE_WIDTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .coefs   (coefs_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // sink: random stalls, plus a long hold when requested
    initial
    begin
        coefs_if.ready = 1'b0;
        hold_left      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                coefs_if.ready = 1'b0;
                hold_left--;
            end
            else
                coefs_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && coefs_if.valid && coefs_if.ready)
            sb.check_coefs({coefs_if.coef_7, coefs_if.coef_6, coefs_if.coef_5,
                            coefs_if.coef_4, coefs_if.coef_3, coefs_if.coef_2,
                            coefs_if.coef_1, coefs_if.coef_0});
    end

    function automatic void drive_samples(block_t b);
        samples_if.sample_0 = b[0];
        samples_if.sample_1 = b[1];
        samples_if.sample_2 = b[2];
        samples_if.sample_3 = b[3];
        samples_if.sample_4 = b[4];
        samples_if.sample_5 = b[5];
        samples_if.sample_6 = b[6];
        samples_if.sample_7 = b[7];
    endfunction

    // mix of full-range, small, extreme and constant-magnitude random-sign blocks
    function automatic block_t rand_block();
        block_t                        b;
        logic [DCT8_SAMPLE_WIDTH-1:0]  level;
        int                            mode;
        int                            i;
        mode  = $urandom_range(0, 9);
        level = DCT8_SAMPLE_WIDTH'($urandom);
        for (i = 0; i < 8; i++)
        begin
            case (mode)
                6, 7:
                    b[i] = 16'($urandom_range(0, 16)) - 16'd8;
                8:
                    case ($urandom_range(0, 3))
                        0:       b[i] = SAMPLE_MAX;
                        1:       b[i] = SAMPLE_MIN;
                        2:       b[i] = '0;
                        default: b[i] = DCT8_SAMPLE_WIDTH'($urandom);
                    endcase
                9:
                    b[i] = $urandom_range(0, 1) ? level : -level;
                default:
                    b[i] = DCT8_SAMPLE_WIDTH'($urandom);
            endcase
        end
        return b;
    endfunction

    // one beat on the sample channel, with random gaps ahead of it
    task automatic send_block(input block_t b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            samples_if.valid = 1'b0;
            drive_samples(block_t'({$urandom, $urandom, $urandom, $urandom}));
            @(negedge clk);
        end
        samples_if.valid = 1'b1;
        drive_samples(b);
        do
            @(posedge clk);
        while (!samples_if.ready);
        sb.note_block(b);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_block(rand_block());
    endtask

    // stop offering and wait for every pending block to come out
    task automatic drain();
        samples_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        block_t b;
        int     i;

        rst_n            = 1'b0;
        samples_if.valid = 1'b0;
        drive_samples('0);
        src_idle_pct     = 34;
        snk_idle_pct     = 34;
        hold_req         = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, alternations, ramps and impulses
        send_block('0);
        send_block({8{SAMPLE_MAX}});
        send_block({8{SAMPLE_MIN}});
        send_block({4{SAMPLE_MIN, SAMPLE_MAX}});
        send_block({4{SAMPLE_MAX, SAMPLE_MIN}});
        send_block({{4{SAMPLE_MIN}}, {4{SAMPLE_MAX}}});
        send_block({{4{SAMPLE_MAX}}, {4{SAMPLE_MIN}}});
        send_block({8{SAMPLE_ONE}});
        send_block({8{SAMPLE_NEG}});
        send_block({16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
        for (i = 0; i < 8; i++)
        begin
            b    = '0;
            b[i] = (i % 2 == 0) ? SAMPLE_MIN : SAMPLE_MAX;
            send_block(b);
        end
        drain();

        // hold the sink while blocks keep coming, so the pipe fills
        hold_req     = 64;
        src_idle_pct = 0;
        send_random(24);
        drain();

        // full-rate stream, no idling on either side
        snk_idle_pct = 0;
        send_random(150);
        drain();

        // random idling on both sides
        src_idle_pct = 34;
        snk_idle_pct = 34;
        send_random(260);
        drain();

        repeat (NUM_STAGES * 4) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
